// ===== hdl/vsl_pkg.sv =====
// Shared types, constants and the arctangent table of the voxel sector labeler.
package vsl_pkg;

  // Angle word: Q4.30 radians, enough headroom for pi plus the atan sum and a 2pi wrap.
  localparam int ZW = 35;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 35'sd6746518852;
  localparam int Q30_FRAC = 30;
  localparam int BOUND_FRAC = 12;
  localparam int CFG_W = 64;
  localparam int IDX_W = 3;
  localparam int LABEL_W = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_SECTOR_MODE = 3'd0,
    REG_LOWER_THR   = 3'd1,
    REG_UPPER_THR   = 3'd2,
    REG_AXIAL_CTR   = 3'd3,
    REG_BOUNDS      = 3'd4,
    REG_NORMAL      = 3'd5,
    REG_OFFSET      = 3'd6
  } vsl_reg_t;

  // Side flags that travel with the angle through the CORDIC chain.
  typedef struct packed {
    logic zero;  // voxel sits exactly on the center
    logic win;   // intensity inside window
    logic side;  // non-negative side of the plane
  } vsl_tag_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0:  v = 35'sd843314857;
      1:  v = 35'sd497837829;
      2:  v = 35'sd263043837;
      3:  v = 35'sd133525159;
      4:  v = 35'sd67021687;
      5:  v = 35'sd33543516;
      6:  v = 35'sd16775851;
      7:  v = 35'sd8388437;
      8:  v = 35'sd4194283;
      9:  v = 35'sd2097149;
      10: v = 35'sd1048576;
      11: v = 35'sd524288;
      12: v = 35'sd262144;
      13: v = 35'sd131072;
      14: v = 35'sd65536;
      15: v = 35'sd32768;
      16: v = 35'sd16384;
      17: v = 35'sd8192;
      18: v = 35'sd4096;
      19: v = 35'sd2048;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/vsl_cordic_stage.sv =====
// One registered vectoring CORDIC micro-rotation.
module vsl_cordic_stage import vsl_pkg::*; #(
  parameter int XW = 43,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  vsl_tag_t             tag_in,
  output logic                 valid_out,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output vsl_tag_t             tag_out
);

  localparam logic signed [ZW-1:0] ATAN = atan_q30(STAGE);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  always_comb begin
    if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out   <= x_next;
      y_out   <= y_next;
      z_out   <= z_next;
      tag_out <= tag_in;
    end
  end

endmodule

// ===== hdl/vsl_sector.sv =====
// Angle wrap and rounding, bound comparison and label output register.
module vsl_sector import vsl_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  logic signed [ZW-1:0] z_in,
  input  vsl_tag_t            tag_in,
  input  logic                sector_mode,
  input  logic [63:0]         sector_bounds,
  output logic                valid_out,
  output logic [LABEL_W-1:0]  label
);

  localparam int SH = Q30_FRAC - ANGLE_FRAC_BITS;
  localparam int AW = ZW - SH + 1;
  localparam int AJW = AW + 1;
  localparam int EA = AJW + BOUND_FRAC;
  localparam int EB = 16 + ANGLE_FRAC_BITS;
  localparam int EW = ((EA > EB) ? EA : EB) + 1;
  localparam logic signed [ZW:0] HALF_LSB = (ZW+1)'(64'sd1 <<< (SH - 1));
  localparam longint TWO_PI_RL = (64'sd6746518852 + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam logic signed [AJW-1:0] TWO_PI_R = AJW'(TWO_PI_RL);

  // round stage
  logic                  r_valid;
  logic signed [AW-1:0]  r_a;
  vsl_tag_t              r_tag;
  logic signed [ZW-1:0]  z_wrap;
  logic signed [ZW:0]    z_round;

  // adjust stage
  logic                  c_valid;
  logic signed [AJW-1:0] c_a;
  vsl_tag_t              c_tag;
  logic signed [EW-1:0]  ea_r;
  logic signed [EW-1:0]  ea_c;
  logic signed [EW-1:0]  eb [4];
  logic                  lt0;
  logic [LABEL_W-1:0]    label_next;
  logic [3:0]            lt;
  logic                  gt3;

  always_comb begin
    if (tag_in.zero) begin
      z_wrap = '0;
    end else if (z_in < -Q30_HALF_PI) begin
      z_wrap = z_in + Q30_TWO_PI;
    end else begin
      z_wrap = z_in;
    end
    z_round = {z_wrap[ZW-1], z_wrap} + HALF_LSB;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      eb[i] = EW'($signed(sector_bounds[16*i +: 16])) <<< ANGLE_FRAC_BITS;
    end
    ea_r = EW'(r_a) <<< BOUND_FRAC;
    ea_c = EW'(c_a) <<< BOUND_FRAC;
    lt0  = ea_r < eb[0];
    for (int i = 0; i < 4; i++) begin
      lt[i] = ea_c < eb[i];
    end
    gt3 = ea_c > eb[3];
  end

  always_comb begin
    label_next = '0;
    if (c_tag.win) begin
      if (!sector_mode) begin
        label_next = LABEL_W'(1);
      end else begin
        priority if (gt3) label_next = LABEL_W'(2);
        else if (lt[0])   label_next = LABEL_W'(2);
        else if (lt[1])   label_next = LABEL_W'(4);
        else if (lt[2])   label_next = LABEL_W'(6);
        else              label_next = LABEL_W'(8);
        if (c_tag.side) begin
          label_next = label_next - LABEL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      c_valid   <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      r_valid   <= valid_in;
      c_valid   <= r_valid;
      valid_out <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_a   <= AW'(z_round >>> SH);
      r_tag <= tag_in;
      c_a   <= lt0 ? (AJW'(r_a) + TWO_PI_R) : AJW'(r_a);
      c_tag <= r_tag;
      label <= label_next;
    end
  end

endmodule

// ===== hdl/voxel_sector_labeler_unit.sv =====
// Top level of the voxel sector labeler: config registers, front end and CORDIC chain.
//
// Usage
//   Input channel: in_valid/in_stall carry one voxel beat (voxel_x, voxel_y,
//   voxel_z, intensity). A beat is taken on a rising edge with in_valid high
//   and in_stall low.
//   Output channel: out_valid/out_stall carry one label beat per voxel, in
//   input order. label is 0 outside the intensity window, 1 in threshold
//   mode, 1..8 in sector mode.
//   Config: cfg_we writes cfg_data into the register picked by cfg_index on
//   the same edge; unknown indexes are dropped. Write only while idle.
// Timing
//   From input beat to label the registers are: capture, pre-rotation plus
//   plane test, one register stage per CORDIC micro-rotation, angle wrap and
//   rounding, 2pi adjust, and bound compare into the output register. One
//   voxel per cycle sustained while out_stall does not hold the pipeline;
//   the CORDIC chain sets the depth.
// Reset
//   rst (sync, active high) clears every valid bit and loads the register
//   defaults (threshold mode, window -32768..0, all else zero).
// Stall
//   While out_valid is high and out_stall is high the whole pipeline holds
//   and in_stall rises; no beat is lost or repeated.
module voxel_sector_labeler_unit import vsl_pkg::*; #(
  parameter int COORD_WIDTH = 10,
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int ATAN_STAGES = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] voxel_x,
  input  logic [COORD_WIDTH-1:0] voxel_y,
  input  logic [COORD_WIDTH-1:0] voxel_z,
  input  logic signed [15:0]     intensity,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LABEL_W-1:0]     label,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  // offset width: 16*coord minus a 16-bit center, plus sign
  localparam int DXW = ((COORD_WIDTH + 4 > 16) ? COORD_WIDTH + 4 : 16) + 1;
  // CORDIC datapath: offsets scaled by 2^24, gain and diagonal headroom
  localparam int XW = DXW + 24 + 2;
  // plane products and the side test
  localparam int PW = 16 + COORD_WIDTH + 1;
  localparam int SW = ((PW + 6 > 40) ? PW + 6 : 40) + 1;

  // config registers
  logic               sector_mode;
  logic signed [15:0] lower_threshold;
  logic signed [15:0] upper_threshold;
  logic [31:0]        axial_center;
  logic [63:0]        sector_bounds;
  logic [47:0]        plane_normal;
  logic signed [39:0] plane_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_mode     <= 1'b0;
      lower_threshold <= 16'sh8000;
      upper_threshold <= '0;
      axial_center    <= '0;
      sector_bounds   <= '0;
      plane_normal    <= '0;
      plane_offset    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SECTOR_MODE: sector_mode     <= cfg_data[0];
        REG_LOWER_THR:   lower_threshold <= cfg_data[15:0];
        REG_UPPER_THR:   upper_threshold <= cfg_data[15:0];
        REG_AXIAL_CTR:   axial_center    <= cfg_data[31:0];
        REG_BOUNDS:      sector_bounds   <= cfg_data;
        REG_NORMAL:      plane_normal    <= cfg_data[47:0];
        REG_OFFSET:      plane_offset    <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output beat is held
  logic adv;
  logic out_valid_int;
  assign adv      = !(out_valid_int && out_stall);
  assign in_stall = out_valid_int && out_stall;

  // stage 1: offsets, window test, plane products
  logic                  s1_valid;
  logic signed [DXW-1:0] s1_dx;
  logic signed [DXW-1:0] s1_dy;
  logic signed [PW-1:0]  s1_px;
  logic signed [PW-1:0]  s1_py;
  logic signed [PW-1:0]  s1_pz;
  logic                  s1_win;

  logic signed [DXW-1:0] dx_next;
  logic signed [DXW-1:0] dy_next;

  assign dx_next = $signed({{(DXW-COORD_WIDTH-4){1'b0}}, voxel_x, 4'b0})
                 - $signed({{(DXW-16){1'b0}}, axial_center[15:0]});
  assign dy_next = $signed({{(DXW-16){1'b0}}, axial_center[31:16]})
                 - $signed({{(DXW-COORD_WIDTH-4){1'b0}}, voxel_y, 4'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx  <= dx_next;
      s1_dy  <= dy_next;
      s1_px  <= $signed(plane_normal[15:0])  * $signed({1'b0, voxel_x});
      s1_py  <= $signed(plane_normal[31:16]) * $signed({1'b0, voxel_y});
      s1_pz  <= $signed(plane_normal[47:32]) * $signed({1'b0, voxel_z});
      s1_win <= (intensity >= lower_threshold) && (intensity <= upper_threshold);
    end
  end

  // stage 2: pi pre-rotation for the left half-plane, plane side test
  logic signed [XW-1:0] dx_s;
  logic signed [XW-1:0] dy_s;
  logic signed [SW-1:0] dot_s;
  vsl_tag_t             tag2_next;

  assign dx_s = {{(XW-24-DXW){s1_dx[DXW-1]}}, s1_dx, 24'b0};
  assign dy_s = {{(XW-24-DXW){s1_dy[DXW-1]}}, s1_dy, 24'b0};
  assign dot_s = ((SW'(s1_px) + SW'(s1_py) + SW'(s1_pz)) <<< 4) - SW'(plane_offset);

  always_comb begin
    tag2_next.zero = (s1_dx == '0) && (s1_dy == '0);
    tag2_next.win  = s1_win;
    tag2_next.side = !dot_s[SW-1];
  end

  logic                 cv [ATAN_STAGES+1];
  logic signed [XW-1:0] cx [ATAN_STAGES+1];
  logic signed [XW-1:0] cy [ATAN_STAGES+1];
  logic signed [ZW-1:0] cz [ATAN_STAGES+1];
  vsl_tag_t             ct [ATAN_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= s1_dx[DXW-1] ? -dx_s : dx_s;
      cy[0] <= s1_dx[DXW-1] ? -dy_s : dy_s;
      cz[0] <= s1_dx[DXW-1] ? Q30_PI : '0;
      ct[0] <= tag2_next;
    end
  end

  // CORDIC chain, one micro-rotation per register stage
  for (genvar g = 0; g < ATAN_STAGES; g++) begin : g_cordic
    vsl_cordic_stage #(
      .XW(XW),
      .STAGE(g)
    ) u_stage (
      .clk(clk),
      .rst(rst),
      .en(adv),
      .valid_in(cv[g]),
      .x_in(cx[g]),
      .y_in(cy[g]),
      .z_in(cz[g]),
      .tag_in(ct[g]),
      .valid_out(cv[g+1]),
      .x_out(cx[g+1]),
      .y_out(cy[g+1]),
      .z_out(cz[g+1]),
      .tag_out(ct[g+1])
    );
  end

  vsl_sector #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_sector (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .valid_in(cv[ATAN_STAGES]),
    .z_in(cz[ATAN_STAGES]),
    .tag_in(ct[ATAN_STAGES]),
    .sector_mode(sector_mode),
    .sector_bounds(sector_bounds),
    .valid_out(out_valid_int),
    .label(label)
  );

  assign out_valid = out_valid_int;

endmodule

// ===== hdl/vsl_checker.sv =====
// Port-level checks of the voxel sector labeler, bound to the top level.
module vsl_checker import vsl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [LABEL_W-1:0] label
);

  // input is held back only by a held output beat
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held output beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(label)))
    else $error("held label beat changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (label <= LABEL_W'(8)))
    else $error("label out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind voxel_sector_labeler_unit vsl_checker u_vsl_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .label(label)
);

// ===== tb/voxel_sector_labeler_unit_chk.sv =====
// Scoreboard for the voxel sector labeler: shadows the registers, predicts each label, compares.
module voxel_sector_labeler_unit_chk import vsl_pkg::*; #(
  parameter int COORD_WIDTH = 10,
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int ATAN_STAGES = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] voxel_x,
  input  logic [COORD_WIDTH-1:0] voxel_y,
  input  logic [COORD_WIDTH-1:0] voxel_z,
  input  logic signed [15:0]     intensity,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [LABEL_W-1:0]     label,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     errors,
  output int                     pending
);

  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint TWO_PI  = 64'sd6746518852;
  localparam int EXP_DEPTH = 64;  // well above the pipeline depth

  // Q2.30 arctangent of 2^-i
  localparam longint ATAN_LUT [20] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048};

  logic                sh_mode;
  logic signed [15:0]  sh_lo, sh_hi;
  logic [31:0]         sh_ctr;
  logic [63:0]         sh_bounds;
  logic [47:0]         sh_normal;
  logic signed [39:0]  sh_offset;
  logic [LABEL_W-1:0]  exp_mem [EXP_DEPTH];
  int                  wr_cnt, rd_cnt;

  function automatic longint vector_angle(longint dx, longint dy);
    longint x, y, z, xs, ys;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx <<< 24;
    y = dy <<< 24;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = PI_Q30;
    end
    for (int i = 0; i < ATAN_STAGES && i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_LUT[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_LUT[i];
      end
    end
    return z;
  endfunction

  function automatic logic [LABEL_W-1:0] predict_label(longint vx, longint vy, longint vz,
                                                       longint inten);
    longint z, a, two_pi_r, dot, bnd [4];
    int sh, lbl;
    sh = 30 - ANGLE_FRAC_BITS;
    if (inten < longint'(sh_lo) || inten > longint'(sh_hi)) return '0;
    if (!sh_mode) return LABEL_W'(1);
    z = vector_angle(vx * 16 - longint'(sh_ctr[15:0]), longint'(sh_ctr[31:16]) - vy * 16);
    two_pi_r = (TWO_PI + (64'sd1 <<< (sh - 1))) >>> sh;
    for (int i = 0; i < 4; i++) bnd[i] = longint'($signed(sh_bounds[16*i +: 16]));
    if (z < -HALF_PI) z = z + TWO_PI;
    a = (z + (64'sd1 <<< (sh - 1))) >>> sh;
    if ((a <<< BOUND_FRAC) < (bnd[0] <<< ANGLE_FRAC_BITS)) a = a + two_pi_r;
    if ((a <<< BOUND_FRAC) > (bnd[3] <<< ANGLE_FRAC_BITS)) begin
      lbl = 2;
    end else begin
      lbl = 8;
      for (int i = 3; i >= 0; i--)
        if ((a <<< BOUND_FRAC) < (bnd[i] <<< ANGLE_FRAC_BITS)) lbl = (i + 1) * 2;
    end
    dot = longint'($signed(sh_normal[15:0])) * vx + longint'($signed(sh_normal[31:16])) * vy
        + longint'($signed(sh_normal[47:32])) * vz;
    if (dot * 16 - longint'(sh_offset) >= 0) lbl = lbl - 1;
    return lbl[LABEL_W-1:0];
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    wr_cnt = 0;
    rd_cnt = 0;
  end

  always @(posedge clk) begin
    logic [LABEL_W-1:0] want;
    if (rst) begin
      sh_mode   <= 1'b0;
      sh_lo     <= -16'sd32768;
      sh_hi     <= '0;
      sh_ctr    <= '0;
      sh_bounds <= '0;
      sh_normal <= '0;
      sh_offset <= '0;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (wr_cnt == rd_cnt) begin
          errors++;
          if (errors <= 10) $display("label beat %0d with nothing expected", label);
        end else begin
          want = exp_mem[rd_cnt % EXP_DEPTH];
          rd_cnt++;
          if (label !== want) begin
            errors++;
            if (errors <= 10) $display("label mismatch: expected %0d, got %0d", want, label);
          end
        end
      end
      if (in_valid && !in_stall) begin
        exp_mem[wr_cnt % EXP_DEPTH] = predict_label(voxel_x, voxel_y, voxel_z, intensity);
        wr_cnt++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SECTOR_MODE: sh_mode   <= cfg_data[0];
          REG_LOWER_THR:   sh_lo     <= cfg_data[15:0];
          REG_UPPER_THR:   sh_hi     <= cfg_data[15:0];
          REG_AXIAL_CTR:   sh_ctr    <= cfg_data[31:0];
          REG_BOUNDS:      sh_bounds <= cfg_data;
          REG_NORMAL:      sh_normal <= cfg_data[47:0];
          REG_OFFSET:      sh_offset <= cfg_data[39:0];
          default: ;
        endcase
      end
    end
    pending = wr_cnt - rd_cnt;
  end

endmodule

// ===== tb/voxel_sector_labeler_unit_tb.sv =====
// Testbench top for the voxel sector labeler: clock, reset, voxel stimulus, receiver and verdict.
module voxel_sector_labeler_unit_tb import vsl_pkg::*;;

  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;  // index with no register behind it
  localparam int IDLE_PCT = 37;
  localparam int DRAIN_CYCLES = 30;    // above the pipeline depth
  localparam int QUIET_LIMIT = 5000;   // cycles with no beat before declaring a hang
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [9:0] voxel_x = '0, voxel_y = '0, voxel_z = '0;
  logic signed [15:0] intensity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LABEL_W-1:0] label;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_SECTOR_MODE;
  logic [CFG_W-1:0] cfg_data = '0;
  int errors, pending;

  // mirror of the window, so random intensities can aim inside it
  int win_lo = -32768, win_hi = 0;
  int send_idle = IDLE_PCT;
  int cyc = 0;
  int quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  voxel_sector_labeler_unit u_top (
    .clk, .rst, .in_valid, .in_stall, .voxel_x, .voxel_y, .voxel_z, .intensity,
    .out_valid, .out_stall, .label, .cfg_we, .cfg_index, .cfg_data);

  voxel_sector_labeler_unit_chk u_chk (
    .clk, .rst, .in_valid, .in_stall, .voxel_x, .voxel_y, .voxel_z, .intensity,
    .out_valid, .out_stall, .label, .cfg_we, .cfg_index, .cfg_data, .errors, .pending);

  // Receiver: random stalls, a calm stretch, and two long hold-offs that
  // back the pipeline up into in_stall while the sender keeps offering.
  always @(negedge clk) begin
    int hold;
    cyc <= cyc + 1;
    if (cyc == 1500 || cyc == 2000) hold = HOLD_CYCLES;
    if (hold > 0) begin
      hold--;
      out_stall <= 1'b1;
    end else if (cyc > 2500 && cyc < 3200) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog on beats in either direction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LOWER_THR) win_lo = $signed(data[15:0]);
    if (idx == REG_UPPER_THR) win_hi = $signed(data[15:0]);
  endtask

  // wait until every label is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_voxel(input int x, input int y, input int z, input int inten);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    voxel_x <= 10'(x);
    voxel_y <= 10'(y);
    voxel_z <= 10'(z);
    intensity <= 16'(inten);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    int inten;
    for (int i = 0; i < n; i++) begin
      if (win_lo <= win_hi && $urandom_range(0, 9) < 7)
        inten = win_lo + int'($urandom_range(0, win_hi - win_lo));
      else
        inten = $signed(16'($urandom));
      send_voxel($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                 inten);
    end
  endtask

  // Sector setup: random center, plane and window; bounds either ascending
  // over [-pi/2, 3pi/2] or raw random bits (unordered).
  task automatic random_sector_setup();
    int b [4];
    int t;
    logic [63:0] packed_b;
    logic [63:0] r;
    cfg_write(REG_SECTOR_MODE, 64'd1);
    cfg_write(REG_LOWER_THR, 64'(-$urandom_range(0, 32768)));
    cfg_write(REG_UPPER_THR, 64'($urandom_range(0, 32767)));
    cfg_write(REG_AXIAL_CTR, {$urandom, $urandom});
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < 4; i++) b[i] = $urandom_range(0, 25736) - 6434;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3 - i; j++)
          if (b[j] > b[j+1]) begin
            t = b[j]; b[j] = b[j+1]; b[j+1] = t;
          end
      for (int i = 0; i < 4; i++) packed_b[16*i +: 16] = b[i][15:0];
    end else begin
      packed_b = {$urandom, $urandom};
    end
    cfg_write(REG_BOUNDS, packed_b);
    r = {$urandom, $urandom};
    // small normals keep the plane inside the volume now and then
    cfg_write(REG_NORMAL, $urandom_range(0, 1) ? r : {3{r[15] ? 16'hFFFF : 16'h0000}} ^
              {r[47:32] & 16'h0fff, r[31:16] & 16'h0fff, r[15:0] & 16'h0fff});
    r = {$urandom, $urandom};
    cfg_write(REG_OFFSET, $urandom_range(0, 1) ? r : 64'($signed(r[27:0])));
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset window is -32768..0, threshold mode
    send_voxel(0, 0, 0, -32768);
    send_voxel(1023, 1023, 1023, 0);
    send_voxel(1023, 0, 1023, 1);
    send_voxel(0, 1023, 0, 32767);
    drain();

    // a write to a missing register must change nothing
    cfg_write(REG_NONE, '1);
    send_voxel(5, 6, 7, -1);
    send_voxel(5, 6, 7, 1);
    drain();

    // empty window
    cfg_write(REG_LOWER_THR, 64'd5);
    cfg_write(REG_UPPER_THR, 64'(-5));
    send_voxel(100, 200, 300, 0);
    send_voxel(100, 200, 300, 5);
    drain();

    // sector mode, center at (512, 512), bounds ending at zero angle
    cfg_write(REG_SECTOR_MODE, 64'd1);
    cfg_write(REG_LOWER_THR, 64'(-32768));
    cfg_write(REG_UPPER_THR, 64'(32767));
    cfg_write(REG_AXIAL_CTR, {32'd0, 16'd8192, 16'd8192});
    cfg_write(REG_BOUNDS, {16'd0, 16'hF830, 16'hF060, 16'hE890});
    cfg_write(REG_NORMAL, {16'd0, 16'd0, 16'd4096});
    cfg_write(REG_OFFSET, 64'(64'sd16 * 4096 * 512));
    send_voxel(512, 512, 0, 0);      // on center, tie with last bound
    send_voxel(511, 512, 0, 0);
    send_voxel(600, 400, 9, -32768);
    send_voxel(400, 600, 9, 32767);
    send_voxel(400, 400, 9, 100);
    send_voxel(600, 600, 9, -100);
    drain();

    // extreme settings
    cfg_write(REG_AXIAL_CTR, '1);
    cfg_write(REG_BOUNDS, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
    cfg_write(REG_NORMAL, {16'h8000, 16'h7FFF, 16'h8000});
    cfg_write(REG_OFFSET, 64'h0000_0080_0000_0000);
    send_voxel(0, 0, 0, 0);
    send_voxel(1023, 1023, 1023, 0);
    send_voxel(1023, 0, 512, 7);
    drain();
    cfg_write(REG_OFFSET, 64'h0000_007F_FFFF_FFFF);
    send_voxel(0, 1023, 1023, 0);
    send_voxel(1023, 1023, 0, 0);
    drain();

    // random phases; phase 2 runs with no sender idling
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0 || ph == 5) begin
        cfg_write(REG_SECTOR_MODE, 64'd0);
        cfg_write(REG_LOWER_THR, 64'($signed(16'($urandom))));
        cfg_write(REG_UPPER_THR, 64'($signed(16'($urandom))));
      end else begin
        random_sector_setup();
      end
      send_idle = (ph == 2) ? 0 : IDLE_PCT;
      send_random(125);
      drain();
    end

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/vsl_pkg.sv
hdl/vsl_cordic_stage.sv
hdl/vsl_sector.sv
hdl/voxel_sector_labeler_unit.sv
hdl/vsl_checker.sv
tb/voxel_sector_labeler_unit_chk.sv
tb/voxel_sector_labeler_unit_tb.sv
